[sv/pds_pkg.sv]
// Shared types and constants of the pixel display stretch block.
package pds_pkg;

    localparam int SAMPLE_W          = 32;
    localparam int COLOR_COUNT_DEF   = 128;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int INDEX_OUT_W       = 7;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX_POS = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX_NEG = 32'sh8000_0000;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_BLANK = 2'd1,
        CFG_LOW   = 2'd2,
        CFG_SCALE = 2'd3
    } t_cfg_index;

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_SQRT   = 1'b1
    } t_stretch_mode;

    typedef struct packed {
        t_stretch_mode               mode;
        logic signed [SAMPLE_W-1:0]  blank;
        logic signed [SAMPLE_W-1:0]  low;
        logic        [SAMPLE_W-1:0]  scale;
    } t_pds_cfg;

    // Classified sample on its way from the front to the back.
    typedef struct packed {
        logic                        frame_start;
        logic                        blank;
        logic                        d_pos;
        logic        [SAMPLE_W-1:0]  d;
        logic signed [SAMPLE_W-1:0]  min;
        logic signed [SAMPLE_W-1:0]  max;
    } t_pds_item;

    typedef struct packed {
        logic                        range_bad;
        logic signed [SAMPLE_W-1:0]  max;
        logic signed [SAMPLE_W-1:0]  min;
        logic [INDEX_OUT_W-1:0]      color_index;
    } t_pds_result;

endpackage

[sv/pixel_display_stretch.sv]
// Top level of the pixel display stretch block: config registers, front, queue, back.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample, tuser: frame_start
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: index, min, max, range_bad
//  cfg       in         i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
//  Back end per word: a blank sample or one at or below range_low goes straight to
//  done; linear mode, or a scaled offset that reaches full scale, passes multiply
//  and evaluate first; square-root mode below full scale also runs the
//  one-bit-per-cycle root iteration and a rounding step.
//  The front takes a word every cycle while the queue has room.
//  Reset (synchronous, active low) restores the registers and clears the running stats.
//  A stalled output holds the back; the queue keeps the front accepting until it fills.
module pixel_display_stretch #(
    parameter int COLOR_COUNT = pds_pkg::COLOR_COUNT_DEF,
    parameter int QUEUE_DEPTH = pds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  pds_pkg::t_cfg_index            i_cfg_index,
    input  logic [pds_pkg::SAMPLE_W-1:0]   i_cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // [31:0] sample
    input  logic [0:0]                     s_axis_tuser,  // [0] frame_start
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] color_index, [38:7] running_min, [70:39] running_max, [71] range_bad
    output logic [71:0]                    m_axis_tdata
);
    import pds_pkg::*;

    t_pds_cfg    r_cfg;
    t_pds_item   w_push_item, w_head_item;
    logic        w_push, w_pop, w_full, w_head_valid;
    t_pds_result w_result;

    // Write the registers only while idle; the block itself does not enforce this and takes writes unconditionally.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= MODE_LINEAR;
            r_cfg.blank <= SAMPLE_MAX_NEG;
            r_cfg.low   <= '0;
            r_cfg.scale <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_cfg.mode  <= t_stretch_mode'(i_cfg_data[0]);
                CFG_BLANK: r_cfg.blank <= i_cfg_data;
                CFG_LOW:   r_cfg.low   <= i_cfg_data;
                CFG_SCALE: r_cfg.scale <= i_cfg_data;
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    // Classify and track stats at the input rate.
    pds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .i_frame_start (s_axis_tuser[0]),
        .i_sample      (s_axis_tdata),
        .i_full        (w_full),
        .o_ready       (s_axis_tready),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    // Decouple the fast front from the iterating back.
    pds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head_item)
    );

    // Compute the color index and hold the result until taken.
    pds_back #(
        .COLOR_COUNT (COLOR_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_head_valid),
        .i_q_item  (w_head_item),
        .o_q_pop   (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (w_result)
    );

    assign m_axis_tdata = w_result;

    // A set range flag means every index so far sat at the bottom.
    a_flag_low_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tdata[6:0] <= 7'd1)
        else $error("range_bad set with a mid-range color index");

    // Stats are ordered once any non-blank sample has been seen.
    a_min_le_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[38:7]) <= $signed(m_axis_tdata[70:39])) ||
            (m_axis_tdata[38:7] == SAMPLE_MAX_POS && m_axis_tdata[70:39] == SAMPLE_MAX_NEG))
        else $error("running_min above running_max");

    // No result survives a reset.
    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

[sv/pds_front.sv]
// Front end: blank test, offset from range_low and running min/max.
module pds_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pds_pkg::t_pds_cfg                 i_cfg,
    input  logic                              i_valid,
    input  logic                              i_frame_start,
    input  logic signed [pds_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_full,
    output logic                              o_ready,
    output logic                              o_push,
    output pds_pkg::t_pds_item                o_item
);
    import pds_pkg::*;

    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;
    logic signed [SAMPLE_W-1:0] w_min_base, w_max_base;
    logic signed [SAMPLE_W:0]   w_diff;
    logic                       w_blank;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign w_blank    = (i_sample == i_cfg.blank);
    assign w_min_base = i_frame_start ? SAMPLE_MAX_POS : r_min;
    assign w_max_base = i_frame_start ? SAMPLE_MAX_NEG : r_max;
    assign w_diff     = {i_sample[SAMPLE_W-1], i_sample} - {i_cfg.low[SAMPLE_W-1], i_cfg.low};

    always_comb begin
        n_min = w_min_base;
        n_max = w_max_base;
        if (!w_blank) begin
            if (i_sample < w_min_base) begin
                n_min = i_sample;
            end
            if (i_sample > w_max_base) begin
                n_max = i_sample;
            end
        end
    end

    always_comb begin
        o_item.frame_start = i_frame_start;
        o_item.blank       = w_blank;
        o_item.d_pos       = !w_diff[SAMPLE_W] && (w_diff != '0);
        o_item.d           = w_diff[SAMPLE_W-1:0];
        o_item.min         = n_min;
        o_item.max         = n_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= SAMPLE_MAX_POS;
            r_max <= SAMPLE_MAX_NEG;
        end else if (o_push) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

endmodule

[sv/pds_queue.sv]
// Small register queue between front and back.
module pds_queue #(
    parameter int DEPTH = pds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pds_pkg::t_pds_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output pds_pkg::t_pds_item o_item
);
    import pds_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pds_item       r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/pds_back.sv]
// Back end: scale multiply, linear or square-root index, range flag, output register.
module pds_back #(
    parameter int COLOR_COUNT = pds_pkg::COLOR_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pds_pkg::t_pds_cfg    i_cfg,
    input  logic                 i_q_valid,
    input  pds_pkg::t_pds_item   i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pds_pkg::t_pds_result o_result
);
    import pds_pkg::*;

    localparam int CM_W  = $clog2(COLOR_COUNT);
    localparam int IDX_W = CM_W + 1;
    localparam int R_W   = CM_W + 16;
    localparam int U_W   = 2 * R_W;
    localparam int CNT_W = $clog2(R_W);
    localparam int LIN_W = CM_W + 33;
    localparam logic [CM_W-1:0]   CM   = CM_W'(COLOR_COUNT - 1);
    localparam logic [2*CM_W-1:0] CM2  = (2*CM_W)'((COLOR_COUNT - 1) * (COLOR_COUNT - 1));
    localparam logic [IDX_W-1:0]  TOP  = IDX_W'(COLOR_COUNT - 2);
    localparam logic [IDX_W-1:0]  EDGE = IDX_W'(COLOR_COUNT - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_EVAL = 7'b0000100,
        S_ROOT = 7'b0001000,
        S_RND  = 7'b0010000,
        S_DONE = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state            r_state;
    t_pds_item         r_item;
    logic [63:0]       r_t;
    logic [U_W-1:0]    r_u;
    logic [R_W-1:0]    r_rem;
    logic [R_W-1:0]    r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_idx;
    logic              r_flag, n_flag;
    logic              r_out_valid;
    t_pds_result       r_out;

    logic [63:0]          w_prod;
    logic [LIN_W-1:0]     w_lin;
    logic [R_W+1:0]       w_rem_sh, w_trial;
    logic [R_W:0]         w_rnd;
    logic                 w_load;
    logic [IDX_W+INDEX_OUT_W-1:0] w_idx_ext;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] x);
        if (x < IDX_W'(1)) begin
            return IDX_W'(1);
        end else if (x > TOP) begin
            return TOP;
        end
        return x;
    endfunction

    assign w_prod   = 64'(r_item.d) * 64'(i_cfg.scale);
    assign w_lin    = LIN_W'(CM) * LIN_W'(r_t[31:0]) + LIN_W'(64'h8000_0000);
    assign w_rem_sh = {r_rem[R_W-1:0], r_u[U_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_rnd    = {1'b0, r_root} + (R_W+1)'(32'h8000);

    assign w_load    = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign n_flag    = (r_item.frame_start || r_flag) &&
                       ((r_idx <= IDX_W'(1)) || (r_idx == EDGE));
    assign w_idx_ext = {{INDEX_OUT_W{1'b0}}, r_idx};

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flag      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_flag      <= n_flag;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.blank || !i_q_item.d_pos) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL:  r_state <= S_EVAL;
                S_EVAL: begin
                    if (r_t[63:32] == '0 && i_cfg.mode == MODE_SQRT) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ROOT: begin
                    if (r_cnt == CNT_W'(R_W - 1)) begin
                        r_state <= S_RND;
                    end
                end
                S_RND:  r_state <= S_DONE;
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_q_item;
                r_idx  <= i_q_item.blank ? '0 : IDX_W'(1);
            end
            S_MUL: begin
                r_t <= w_prod;
            end
            S_EVAL: begin
                if (r_t[63:32] != '0) begin
                    r_idx <= TOP;
                end else begin
                    r_idx <= clamp_idx(w_lin[LIN_W-1:32]);
                end
                r_u    <= U_W'(CM2 * U_W'(r_t[31:0]));
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            S_ROOT: begin
                // One result bit per cycle, two radicand bits consumed.
                // The remainder fits R_W bits up to the last step, whose
                // remainder is dropped.
                r_u   <= r_u << 2;
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= R_W'(w_rem_sh - w_trial);
                    r_root <= {r_root[R_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh[R_W-1:0];
                    r_root <= {r_root[R_W-2:0], 1'b0};
                end
            end
            S_RND: begin
                r_idx <= clamp_idx(w_rnd[R_W:16]);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
        if (w_load) begin
            r_out.color_index <= w_idx_ext[INDEX_OUT_W-1:0];
            r_out.min         <= r_item.min;
            r_out.max         <= r_item.max;
            r_out.range_bad   <= n_flag;
        end
    end

endmodule

[verif/testbench.sv]
// Self-checking testbench of the pixel display stretch block: directed table, random phases.
`timescale 1ns / 1ps

module testbench;
    import pds_pkg::*;

    typedef longint unsigned t_u64;

    localparam int COLORS        = COLOR_COUNT_DEF;
    localparam int TOP_INDEX     = COLORS - 2;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 104;
    localparam int RANDOM_WORDS  = PHASES * PHASE_WORDS;
    localparam int QUIET_WORDS   = 100;
    localparam int DIRECTED_ROWS = 23;

    // One row of the directed table: the register setting it runs under, the
    // word to send and, where it is obvious, the color index to expect.
    typedef struct packed {
        t_stretch_mode mode;
        logic [31:0]   blank;
        logic [31:0]   low;
        logic [31:0]   scale;
        logic          fs;
        logic [31:0]   sample;
        logic          has_idx;
        logic [6:0]    idx;
    } t_stim_row;

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // reset setting: linear, blank at most negative, low 0, scale 1.0
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h8000_0000, 1'b1, 7'd0},
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0000_0000, 1'b1, 7'd1},
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0001_0000, 1'b1, 7'd126},
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h7FFF_FFFF, 1'b1, 7'd126},
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0000_8000, 1'b1, 7'd64},
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'hFFFF_FFFF, 1'b1, 7'd1},
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_0001, 1'b0, 7'd0},
        // square root over the unit range
        '{MODE_SQRT,   32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_4000, 1'b1, 7'd64},
        '{MODE_SQRT,   32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'hFFFF_0000, 1'b1, 7'd1},
        '{MODE_SQRT,   32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0001_0000, 1'b1, 7'd126},
        '{MODE_SQRT,   32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0000_0001, 1'b0, 7'd0},
        '{MODE_SQRT,   32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0000_C000, 1'b0, 7'd0},
        // zero scale: every non-blank word lands on index 1
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1, 7'd1},
        '{MODE_LINEAR, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h1234_5678, 1'b1, 7'd1},
        // lowest low, largest scale, blank at most positive
        '{MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b1, 7'd0},
        '{MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 1'b1, 7'd1},
        '{MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h8000_0001, 1'b0, 7'd0},
        '{MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h7FFF_FFFE, 1'b1, 7'd126},
        // highest low, smallest nonzero scale, blank at zero
        '{MODE_SQRT,   32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF, 1'b1, 7'd1},
        '{MODE_SQRT,   32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b1, 7'd0},
        '{MODE_SQRT,   32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 32'h8000_0000, 1'b1, 7'd1},
        // frame start on a blank word: stats show their cleared values
        '{MODE_SQRT,   32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b1, 7'd0},
        '{MODE_SQRT,   32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h8000_0001, 1'b0, 7'd0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    t_cfg_index  i_cfg_index   = CFG_MODE;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] sample
    logic [0:0]  s_axis_tuser  = '0;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [6:0] color_index, [38:7] running_min, [70:39] running_max, [71] range_bad
    logic [71:0] m_axis_tdata;

    pixel_display_stretch u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Predictor's copy of the registers, at their reset values.
    t_stretch_mode      cfg_mode  = MODE_LINEAR;
    logic signed [31:0] cfg_blank = SAMPLE_MAX_NEG;
    logic signed [31:0] cfg_low   = '0;
    logic        [31:0] cfg_scale = 32'h0001_0000;

    // Predictor's copy of the per-frame statistics.
    logic signed [31:0] seen_min = SAMPLE_MAX_POS;
    logic signed [31:0] seen_max = SAMPLE_MAX_NEG;
    logic               seen_bad = 1'b1;

    t_pds_result pending_words[$];

    int  err_count     = 0;
    int  words_sent    = 0;
    int  words_checked = 0;
    int  blank_words   = 0;
    int  sqrt_words    = 0;
    int  frame_starts  = 0;
    bit  quiet         = 1'b0;

    // Bitwise integer square root: floor(sqrt(u)).
    function automatic t_u64 root_floor(input t_u64 u);
        t_u64 x, r, b;
        x = u;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Color index of a non-blank sample under the current registers.
    function automatic logic [6:0] stretch_index(input logic signed [31:0] s);
        longint d;
        t_u64   t, idx, cm;
        cm = COLORS - 1;
        d  = longint'(s) - longint'(cfg_low);
        if (d <= 0)
            return 7'd1;
        // t is (v-low)*scale in Q32.32; one or more saturates
        t = t_u64'(d) * t_u64'(cfg_scale);
        if ((t >> 32) != 0)
            return 7'(TOP_INDEX);
        if (cfg_mode == MODE_SQRT)
            idx = (root_floor(cm * cm * t) + 64'd32768) >> 16;
        else
            idx = (cm * t + 64'h8000_0000) >> 32;
        if (idx < 1)
            idx = 1;
        if (idx > TOP_INDEX)
            idx = TOP_INDEX;
        return 7'(idx);
    endfunction

    // Advance the frame statistics by one word and return the output word it gives.
    function automatic t_pds_result predict_word(input logic fs, input logic [31:0] sample);
        t_pds_result        w;
        logic signed [31:0] s;
        logic [6:0]         idx;
        s = $signed(sample);
        if (fs) begin
            seen_min = SAMPLE_MAX_POS;
            seen_max = SAMPLE_MAX_NEG;
            seen_bad = 1'b1;
        end
        if (s == cfg_blank) begin
            idx = 7'd0;
        end else begin
            if (s > seen_max)
                seen_max = s;
            if (s < seen_min)
                seen_min = s;
            idx = stretch_index(s);
        end
        seen_bad = seen_bad && (idx <= 1 || idx == COLORS - 1);
        w.color_index = idx;
        w.min         = seen_min;
        w.max         = seen_max;
        w.range_bad   = seen_bad;
        return w;
    endfunction

    // Write all four registers, one per clock, and mirror them in the predictor.
    task automatic load_regs(input t_stretch_mode mode, input logic [31:0] blank,
                             input logic [31:0] low, input logic [31:0] scale);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= {31'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_BLANK;
        i_cfg_data  <= blank;
        @(posedge i_clk);
        i_cfg_index <= CFG_LOW;
        i_cfg_data  <= low;
        @(posedge i_clk);
        i_cfg_index <= CFG_SCALE;
        i_cfg_data  <= scale;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_mode  = mode;
        cfg_blank = blank;
        cfg_low   = low;
        cfg_scale = scale;
    endtask

    // Drop tvalid and hold until every expected word has come out, then let the
    // back end settle before the registers change.
    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Offer one word, optionally after a random gap, and queue its prediction
    // once it is accepted. A typed index, where given, replaces the predicted one.
    task automatic send_word(input logic fs, input logic [31:0] sample,
                             input logic has_idx, input logic [6:0] idx);
        int          gap;
        t_pds_result w;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (cfg_mode == MODE_SQRT)
            sqrt_words++;
        if ($signed(sample) == cfg_blank)
            blank_words++;
        if (fs)
            frame_starts++;
        w = predict_word(fs, sample);
        if (has_idx)
            w.color_index = idx;
        pending_words.push_back(w);
        words_sent++;
    endtask

    // Random sample: mostly inside a window around the display range, with
    // blanks, full-range noise, extremes and words right at range_low mixed in.
    function automatic logic [31:0] pick_sample();
        t_u64   width, span;
        longint off;
        if (cfg_scale == 0)
            width = 64'h1_0000;
        else
            width = 64'h1_0000_0000 / cfg_scale;
        span = width + width / 4 + 1;
        case ($urandom_range(0, 15))
            0:       return cfg_blank;
            1:       return $urandom;
            2:       return $urandom_range(0, 1) ? SAMPLE_MAX_POS : SAMPLE_MAX_NEG;
            3:       return 32'(longint'(cfg_low) + longint'($urandom_range(0, 2)) - 1);
            default: begin
                off = longint'({$urandom, $urandom} % span) - longint'(width / 8);
                return 32'(longint'(cfg_low) + off);
            end
        endcase
    endfunction

    // Output stall generator: random stall bursts, calm stretches in between,
    // and always ready once the quiet tail starts.
    int stall_left = 0;
    int calm_left  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left--;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 15) == 0)
                calm_left = $urandom_range(20, 80);
            m_axis_tready <= 1'b1;
        end
    end

    // Check each accepted output word against the oldest prediction.
    always @(posedge i_clk) begin : check_output
        t_pds_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, m_axis_tdata);
                err_count++;
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (got.color_index !== want.color_index) begin
                    $display("%0t: color_index expected %0d got %0d",
                             $time, want.color_index, got.color_index);
                    err_count++;
                end
                if (got.min !== want.min) begin
                    $display("%0t: running_min expected %h got %h", $time, want.min, got.min);
                    err_count++;
                end
                if (got.max !== want.max) begin
                    $display("%0t: running_max expected %h got %h", $time, want.max, got.max);
                    err_count++;
                end
                if (got.range_bad !== want.range_bad) begin
                    $display("%0t: range_bad expected %0b got %0b",
                             $time, want.range_bad, got.range_bad);
                    err_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases with fresh registers.
    initial begin : stimulus
        t_stim_row     row;
        t_stretch_mode mode;
        logic [31:0]   blank, low, scale;
        int            n;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table; change registers only when a row asks for a new setting.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.mode != cfg_mode || row.blank != cfg_blank ||
                row.low != cfg_low || row.scale != cfg_scale) begin
                drain_words();
                load_regs(row.mode, row.blank, row.low, row.scale);
            end
            send_word(row.fs, row.sample, row.has_idx, row.idx);
        end

        n = 0;
        for (int p = 0; p < PHASES; p++) begin
            mode  = t_stretch_mode'($urandom_range(0, 1));
            blank = $urandom_range(0, 1) ? $urandom : 32'h8000_0000;
            case (p)
                // extremes first: lowest low with largest scale, then highest low
                // with zero scale, then lowest low in square root
                0: begin
                    mode  = MODE_LINEAR;
                    low   = 32'h8000_0000;
                    scale = 32'hFFFF_FFFF;
                end
                1: begin
                    low   = 32'h7FFF_FFFF;
                    scale = 32'h0000_0000;
                end
                2: begin
                    mode  = MODE_SQRT;
                    low   = 32'h8000_0000;
                    scale = 32'h0000_0100 | $urandom_range(0, 255);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       low = $urandom;
                        1:       low = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                        default: low = 32'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000;
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        scale = $urandom;
                    else
                        scale = 32'(64'h1_0000_0000 /
                                    t_u64'($urandom_range(16, 32'h1 << $urandom_range(5, 31))));
                end
            endcase
            drain_words();
            load_regs(mode, blank, low, scale);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (n >= RANDOM_WORDS - QUIET_WORDS)
                    quiet = 1'b1;
                send_word($urandom_range(0, 15) == 0, pick_sample(), 1'b0, 7'd0);
                n++;
            end
        end

        drain_words();

        $display("Sent %0d words (%0d blank, %0d square root, %0d frame starts), checked %0d.",
                 words_sent, blank_words, sqrt_words, frame_starts, words_checked);
        $display("Covered %0d register settings and %0d mismatches were seen.",
                 PHASES + 6, err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
